[hdl/bc1_pkg.sv]
// Shared types and constants for the BC1 color block decoder.
// No dependencies; every other file in hdl but bc1_if uses it by scoped names.
package bc1_pkg;

    localparam int unsigned TEXELS      = 16;
    localparam int unsigned TEXEL_W     = 4;
    localparam int unsigned INDEX_W     = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

    localparam logic [9:0]  RECIP3       = 10'd683;
    localparam int unsigned RECIP3_SHIFT = 11;

    localparam logic [TEXEL_W-1:0] LAST_TEXEL = TEXEL_W'(TEXELS - 1);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_rgba;

    typedef t_rgba [3:0] t_palette;

    typedef struct packed {
        t_palette    palette;
        logic [31:0] indices;
    } t_entry;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    function automatic logic [7:0] third(input logic [9:0] x);
        logic [19:0] prod;
        prod  = 20'(x) * 20'(RECIP3);
        third = prod[RECIP3_SHIFT +: 8];
    endfunction

endpackage

[hdl/bc1_if.sv]
// Valid/ready channel interfaces for blocks in and texels out.
// Depends on nothing.
interface bc1_blk_if;
    logic        valid;
    logic        ready;
    logic [15:0] endpoint_zero;
    logic [15:0] endpoint_one;
    logic [31:0] texel_indices;
    logic        block_absent;

    modport source (output valid, endpoint_zero, endpoint_one, texel_indices, block_absent,
                    input ready);
    modport sink   (input valid, endpoint_zero, endpoint_one, texel_indices, block_absent,
                    output ready);
endinterface

interface bc1_tex_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [3:0] texel_number;
    logic       last_texel;

    modport source (output valid, blue, green, red, alpha, texel_number, last_texel,
                    input ready);
    modport sink   (input valid, blue, green, red, alpha, texel_number, last_texel,
                    output ready);
endinterface

[hdl/bc1_front.sv]
// Front end: accepts a block, expands endpoints and registers the palette.
// Depends on bc1_pkg and bc1_blk_if.
module bc1_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bc1_blk_if.sink           i_blk,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output bc1_pkg::t_entry   o_push_entry
);

    logic            r_valid;
    bc1_pkg::t_entry r_entry;
    bc1_pkg::t_entry n_entry;
    bc1_pkg::t_rgba  c0;
    bc1_pkg::t_rgba  c1;
    logic            four_color;
    logic            take;

    assign i_blk.ready  = !r_valid || i_push_ready;
    assign take         = i_blk.valid && i_blk.ready;
    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

    always_comb begin
        c0.blue  = bc1_pkg::widen5(i_blk.endpoint_zero[4:0]);
        c0.green = bc1_pkg::widen6(i_blk.endpoint_zero[10:5]);
        c0.red   = bc1_pkg::widen5(i_blk.endpoint_zero[15:11]);
        c0.alpha = bc1_pkg::ALPHA_OPAQUE;
        c1.blue  = bc1_pkg::widen5(i_blk.endpoint_one[4:0]);
        c1.green = bc1_pkg::widen6(i_blk.endpoint_one[10:5]);
        c1.red   = bc1_pkg::widen5(i_blk.endpoint_one[15:11]);
        c1.alpha = bc1_pkg::ALPHA_OPAQUE;
        four_color = i_blk.endpoint_one < i_blk.endpoint_zero;

        n_entry.indices    = i_blk.texel_indices;
        n_entry.palette[0] = c0;
        n_entry.palette[1] = c1;
        if (four_color) begin
            n_entry.palette[2].blue  = bc1_pkg::third({1'b0, c0.blue, 1'b0}
                                       + 10'(c1.blue) + 10'd1);
            n_entry.palette[2].green = bc1_pkg::third({1'b0, c0.green, 1'b0}
                                       + 10'(c1.green) + 10'd1);
            n_entry.palette[2].red   = bc1_pkg::third({1'b0, c0.red, 1'b0}
                                       + 10'(c1.red) + 10'd1);
            n_entry.palette[2].alpha = bc1_pkg::ALPHA_OPAQUE;
            n_entry.palette[3].blue  = bc1_pkg::third({1'b0, c1.blue, 1'b0}
                                       + 10'(c0.blue) + 10'd1);
            n_entry.palette[3].green = bc1_pkg::third({1'b0, c1.green, 1'b0}
                                       + 10'(c0.green) + 10'd1);
            n_entry.palette[3].red   = bc1_pkg::third({1'b0, c1.red, 1'b0}
                                       + 10'(c0.red) + 10'd1);
            n_entry.palette[3].alpha = bc1_pkg::ALPHA_OPAQUE;
        end else begin
            n_entry.palette[2].blue  = 8'((9'(c0.blue) + 9'(c1.blue)) >> 1);
            n_entry.palette[2].green = 8'((9'(c0.green) + 9'(c1.green)) >> 1);
            n_entry.palette[2].red   = 8'((9'(c0.red) + 9'(c1.red)) >> 1);
            n_entry.palette[2].alpha = bc1_pkg::ALPHA_OPAQUE;
            n_entry.palette[3]       = '0;
            n_entry.palette[3].alpha = bc1_pkg::ALPHA_CLEAR;
        end
        if (i_blk.block_absent) begin
            n_entry.palette = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry <= n_entry;
        end
    end

endmodule

[hdl/bc1_queue.sv]
// Short queue of decoded palettes between front and back ends.
// Depends on bc1_pkg.
module bc1_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  bc1_pkg::t_entry   i_push_entry,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output bc1_pkg::t_entry   o_pop_entry
);

    localparam int unsigned PTR_W = $clog2(bc1_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(bc1_pkg::QUEUE_DEPTH + 1);

    bc1_pkg::t_entry  r_mem [bc1_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(bc1_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(bc1_pkg::QUEUE_DEPTH - 1)) ? '0
                            : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(bc1_pkg::QUEUE_DEPTH - 1)) ? '0
                            : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

[hdl/bc1_back.sv]
// Back end: walks the sixteen indices of a palette into registered texels.
// Depends on bc1_pkg and bc1_tex_if.
module bc1_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  bc1_pkg::t_entry   i_pop_entry,
    bc1_tex_if.source         o_tex
);

    logic                         r_loaded;
    bc1_pkg::t_entry              r_entry;
    logic [bc1_pkg::TEXEL_W-1:0]  r_cnt;
    logic                         r_out_valid;
    bc1_pkg::t_rgba               r_out;
    logic [bc1_pkg::TEXEL_W-1:0]  r_out_num;
    logic                         r_out_last;
    logic                         advance;
    logic                         issue;
    logic                         at_last;
    logic                         pop;
    logic [bc1_pkg::INDEX_W-1:0]  sel;

    assign advance     = !r_out_valid || o_tex.ready;
    assign issue       = r_loaded && advance;
    assign at_last     = r_cnt == bc1_pkg::LAST_TEXEL;
    assign o_pop_ready = !r_loaded || (issue && at_last);
    assign pop         = i_pop_valid && o_pop_ready;
    assign sel         = r_entry.indices[{r_cnt, 1'b0} +: bc1_pkg::INDEX_W];

    assign o_tex.valid        = r_out_valid;
    assign o_tex.blue         = r_out.blue;
    assign o_tex.green        = r_out.green;
    assign o_tex.red          = r_out.red;
    assign o_tex.alpha        = r_out.alpha;
    assign o_tex.texel_number = r_out_num;
    assign o_tex.last_texel   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_loaded <= 1'b1;
                r_cnt    <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + bc1_pkg::TEXEL_W'(1);
                if (at_last) begin
                    r_loaded <= 1'b0;
                end
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (o_tex.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_entry <= i_pop_entry;
        end
        if (issue) begin
            r_out      <= r_entry.palette[sel];
            r_out_num  <= r_cnt;
            r_out_last <= at_last;
        end
    end

endmodule

[hdl/bc1_block_decoder.sv]
// BC1 color block decoder: one block in, sixteen texels out.
// Path: front palette register, queue, back entry register, output texel register.
// Throughput: one texel per cycle while o_tex.ready is high, set by the back end's
// texel counter; the two-entry queue lets the front take blocks ahead.
// Reset: synchronous, active low; clears valid flags, pointers and counters only.
module bc1_block_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bc1_blk_if.sink   i_blk,
    bc1_tex_if.source o_tex
);

    logic            push_valid;
    logic            push_ready;
    bc1_pkg::t_entry push_entry;
    logic            pop_valid;
    logic            pop_ready;
    bc1_pkg::t_entry pop_entry;

    bc1_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk        (i_blk),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    bc1_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    bc1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_tex       (o_tex)
    );

endmodule

[tb/bc1_block_decoder_tb.sv]
// Self-checking bench for bc1_block_decoder: a directed table of blocks, then random blocks.
// Each accepted block is expanded to its sixteen expected texels; the texels are checked
// in order as they leave the block. Depends on bc1_pkg and the channels in bc1_if.
module bc1_block_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_ROWS    = 23;
    localparam int unsigned OPEN_BLOCKS   = 40;
    localparam int unsigned SQUEEZE_BLOCKS = 14;
    localparam int unsigned TAIL_BLOCKS   = 233;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 750_000;
    localparam int unsigned MAX_PRINTS    = 40;

    typedef struct packed {
        logic [15:0] ep0;
        logic [15:0] ep1;
        logic [31:0] idx;
        logic        absent;
    } t_block;

    typedef struct packed {
        t_block         blk;
        logic           typed;
        bc1_pkg::t_rgba color;
    } t_stim_row;

    typedef struct packed {
        bc1_pkg::t_rgba color;
        logic [3:0]     number;
        logic           last;
    } t_texel;

    // color is {blue, green, red, alpha}; typed rows expect that one color on every texel
    localparam t_stim_row DIRECTED_BLOCKS [TABLE_ROWS] = '{
        '{'{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{16'h0000, 16'h0000, 32'h0000_0000, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0}, 1'b1, 32'hFFFF_FFFF},
        '{'{16'hFFFF, 16'h0000, 32'h5555_5555, 1'b0}, 1'b1, 32'h0000_00FF},
        '{'{16'hFFFF, 16'h0000, 32'hAAAA_AAAA, 1'b0}, 1'b1, 32'hAAAA_AAFF},
        '{'{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0}, 1'b1, 32'h5555_55FF},
        '{'{16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0}, 1'b1, 32'h0000_0000},
        '{'{16'h0000, 16'h0000, 32'h0000_0000, 1'b0}, 1'b1, 32'h0000_00FF},
        '{'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0}, 1'b1, 32'h0000_0000},
        '{'{16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA, 1'b0}, 1'b1, 32'hFFFF_FFFF},
        '{'{16'h0000, 16'hFFFF, 32'hAAAA_AAAA, 1'b0}, 1'b1, 32'h7F7F_7FFF},
        '{'{16'h0000, 16'hFFFF, 32'h5555_5555, 1'b0}, 1'b1, 32'hFFFF_FFFF},
        '{'{16'h1234, 16'h1233, 32'hE4E4_E4E4, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h1233, 16'h1234, 32'h1B1B_1B1B, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'hF800, 16'h07E0, 32'hE4E4_E4E4, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h001F, 16'hF800, 32'hD8D8_D8D8, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h8000, 16'h7FFF, 32'h3210_FEDC, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h7FFF, 16'h8000, 32'h7654_3210, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'hAAAA, 16'h5555, 32'h1234_5678, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h5555, 16'hAAAA, 32'h9ABC_DEF0, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h1234, 16'h5678, 32'hE4E4_E4E4, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{16'hFFFF, 16'hFFFE, 32'hE4E4_E4E4, 1'b0}, 1'b0, 32'h0000_0000},
        '{'{16'h0001, 16'h0000, 32'hFFFF_FFFF, 1'b0}, 1'b0, 32'h0000_0000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bc1_blk_if blk ();
    bc1_tex_if tex ();

    bc1_block_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk),
        .o_tex   (tex)
    );

    t_texel      texels_due [$];
    bit          idle_on;
    bit          hold_request;
    int unsigned mismatches;
    int unsigned texels_checked;
    int unsigned blocks_sent;
    int unsigned four_color_blocks;
    int unsigned three_color_blocks;
    int unsigned absent_blocks;
    int unsigned input_stalls;
    int unsigned cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("ERROR %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(12, 30);
    endfunction

    function automatic void predict_texels(input t_block b, input logic typed,
                                           input bc1_pkg::t_rgba color);
        int          pal [4][4];
        int          k;
        int          ch;
        int          t;
        int          sel;
        logic [15:0] c;
        t_texel      tx;
        for (k = 0; k < 2; k++) begin
            c = (k == 0) ? b.ep0 : b.ep1;
            pal[k][0] = (int'(c[4:0]) * 33) >> 2;
            pal[k][1] = (int'(c[10:5]) * 65) >> 4;
            pal[k][2] = (int'(c[15:11]) * 33) >> 2;
            pal[k][3] = 255;
        end
        if (b.ep1 < b.ep0) begin
            for (ch = 0; ch < 3; ch++) begin
                pal[2][ch] = (2 * pal[0][ch] + pal[1][ch] + 1) / 3;
                pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch] + 1) / 3;
            end
            pal[2][3] = 255;
            pal[3][3] = 255;
        end else begin
            for (ch = 0; ch < 3; ch++) begin
                pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                pal[3][ch] = 0;
            end
            pal[2][3] = 255;
            pal[3][3] = 0;
        end
        if (b.absent)
            absent_blocks++;
        else if (b.ep1 < b.ep0)
            four_color_blocks++;
        else
            three_color_blocks++;
        for (t = 0; t < bc1_pkg::TEXELS; t++) begin
            sel = int'(b.idx[5'(2*t) +: 2]);
            if (typed) begin
                tx.color = color;
            end else if (b.absent) begin
                tx.color = '0;
            end else begin
                tx.color.blue  = 8'(pal[sel][0]);
                tx.color.green = 8'(pal[sel][1]);
                tx.color.red   = 8'(pal[sel][2]);
                tx.color.alpha = 8'(pal[sel][3]);
            end
            tx.number = 4'(t);
            tx.last   = (4'(t) == bc1_pkg::LAST_TEXEL);
            texels_due.push_back(tx);
        end
    endfunction

    function automatic t_block random_block();
        t_block      b;
        int unsigned pick;
        logic [1:0]  code;
        b.ep0    = 16'($urandom);
        b.ep1    = 16'($urandom);
        b.idx    = $urandom;
        b.absent = 1'b0;
        code     = 2'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 8) begin
            b.absent = 1'b1;
        end else if (pick < 18) begin
            b.ep1 = b.ep0;
        end else if (pick < 26) begin
            b.ep1 = b.ep0 + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
        end else if (pick < 34) begin
            b.ep0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            b.ep1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (pick < 42) begin
            b.idx = {16{code}};
        end
        return b;
    endfunction

    task automatic push_block(input t_block b, input logic typed,
                              input bc1_pkg::t_rgba color);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            blk.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        blk.valid         <= 1'b1;
        blk.endpoint_zero <= b.ep0;
        blk.endpoint_one  <= b.ep1;
        blk.texel_indices <= b.idx;
        blk.block_absent  <= b.absent;
        @(posedge i_clk);
        while (!blk.ready)
            @(posedge i_clk);
        predict_texels(b, typed, color);
        blocks_sent++;
    endtask

    initial begin : texel_sink
        int unsigned low_left;
        int unsigned high_left;
        int unsigned hold_left;
        bit          hold_taken;
        low_left   = 0;
        high_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        tex.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!i_rst_n || hold_left > 0) begin
                if (hold_left > 0)
                    hold_left--;
                tex.ready <= 1'b0;
            end else if (low_left > 0) begin
                low_left--;
                tex.ready <= 1'b0;
            end else begin
                tex.ready <= 1'b1;
                if (high_left > 0) begin
                    high_left--;
                end else begin
                    high_left = $urandom_range(0, 23);
                    low_left  = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin : texel_check
        t_texel want;
        if (i_rst_n) begin
            if (blk.valid && !blk.ready)
                input_stalls++;
            if (tex.valid && tex.ready) begin
                if (texels_due.size() == 0) begin
                    flag_mismatch($sformatf("texel %0d arrived with none expected",
                                            tex.texel_number));
                end else begin
                    want = texels_due.pop_front();
                    if (tex.blue !== want.color.blue)
                        flag_mismatch($sformatf("texel %0d blue %h, want %h",
                                                texels_checked, tex.blue, want.color.blue));
                    if (tex.green !== want.color.green)
                        flag_mismatch($sformatf("texel %0d green %h, want %h",
                                                texels_checked, tex.green, want.color.green));
                    if (tex.red !== want.color.red)
                        flag_mismatch($sformatf("texel %0d red %h, want %h",
                                                texels_checked, tex.red, want.color.red));
                    if (tex.alpha !== want.color.alpha)
                        flag_mismatch($sformatf("texel %0d alpha %h, want %h",
                                                texels_checked, tex.alpha, want.color.alpha));
                    if (tex.texel_number !== want.number)
                        flag_mismatch($sformatf("texel %0d number %0d, want %0d",
                                                texels_checked, tex.texel_number, want.number));
                    if (tex.last_texel !== want.last)
                        flag_mismatch($sformatf("texel %0d last %b, want %b",
                                                texels_checked, tex.last_texel, want.last));
                    texels_checked++;
                end
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("bc1_block_decoder_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int i;
        i_rst_n           = 1'b0;
        blk.valid         = 1'b0;
        blk.endpoint_zero = '0;
        blk.endpoint_one  = '0;
        blk.texel_indices = '0;
        blk.block_absent  = 1'b0;
        idle_on           = 1'b1;
        hold_request      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < TABLE_ROWS; i++)
            push_block(DIRECTED_BLOCKS[i].blk, DIRECTED_BLOCKS[i].typed,
                       DIRECTED_BLOCKS[i].color);

        idle_on = 1'b0;
        for (i = 0; i < OPEN_BLOCKS; i++)
            push_block(random_block(), 1'b0, '0);

        // hold the texel side off while blocks keep coming
        hold_request = 1'b1;
        for (i = 0; i < SQUEEZE_BLOCKS; i++)
            push_block(random_block(), 1'b0, '0);

        idle_on = 1'b1;
        for (i = 0; i < TAIL_BLOCKS; i++)
            push_block(random_block(), 1'b0, '0);

        @(negedge i_clk);
        blk.valid <= 1'b0;
        while (texels_due.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("run: %0d blocks (%0d four-color, %0d three-color, %0d absent), %0d texels",
                 blocks_sent, four_color_blocks, three_color_blocks, absent_blocks,
                 texels_checked);
        $display("run: input back-pressured for %0d cycles, %0d mismatches in %0d cycles",
                 input_stalls, mismatches, cycles);
        if (mismatches == 0)
            $display("bc1_block_decoder_tb: done, clean");
        else
            $display("bc1_block_decoder_tb: done, errors");
        $finish;
    end

endmodule
